/* rtl/core/arc_pkg.sv */
// ----------------------------------------------------------------------------
// Address resolution cache package
// Shared constants, codes and types for the cache controller and datapath.
// ----------------------------------------------------------------------------
package arc_pkg;

	localparam int RECORD_COUNT = 32;
	localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_COUNT - 1);

	localparam logic [2:0] OP_REQUEST = 3'd0;
	localparam logic [2:0] OP_ADD     = 3'd1;
	localparam logic [2:0] OP_IP2MAC  = 3'd2;
	localparam logic [2:0] OP_MAC2IP  = 3'd3;
	localparam logic [2:0] OP_CHECK   = 3'd4;
	localparam logic [2:0] OP_TICK    = 3'd5;

	localparam logic [1:0] RES_OK     = 2'd0;
	localparam logic [1:0] RES_MISS   = 2'd1;
	localparam logic [1:0] RES_REJECT = 2'd2;

	localparam logic [1:0] REG_CACHE    = 2'd0;
	localparam logic [1:0] REG_FREEZE   = 2'd1;
	localparam logic [1:0] REG_REPLY    = 2'd2;
	localparam logic [1:0] REG_ATTEMPTS = 2'd3;

	localparam logic [31:0] CACHE_RST    = 32'(3600 * 1000);
	localparam logic [31:0] FREEZE_RST   = 32'(1800 * 1000);
	localparam logic [31:0] REPLY_RST    = 32'(1 * 1000);
	localparam logic [3:0]  ATTEMPTS_RST = 4'd3;

	typedef enum logic [1:0] {
		REC_EMPTY = 2'd0,
		REC_WANT  = 2'd1,
		REC_SENT  = 2'd2,
		REC_VALID = 2'd3
	} rec_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_TICK,
		ST_DRAIN,
		ST_WRITE
	} ctrl_state_t;

	typedef struct packed {
		logic [31:0] cache_to;
		logic [31:0] freeze_to;
		logic [31:0] reply_to;
		logic [3:0]  attempts;
	} cfg_t;

	typedef struct packed {
		logic            load;
		logic            scan_rd;
		logic            tick_rd;
		logic            commit;
		logic [IDX_W-1:0] rd_addr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
	} dp_sts_t;

endpackage

/* rtl/core/arc_if.sv */
// ----------------------------------------------------------------------------
// Address resolution cache channels
// Valid/ready interfaces for the request words and the result words.
// ----------------------------------------------------------------------------
interface arc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] ip_addr;
	logic [47:0] mac_addr;
	logic [31:0] now_ms;
	logic        resolver_busy;

	modport source (output valid, opcode, ip_addr, mac_addr, now_ms, resolver_busy,
		input ready);
	modport sink (input valid, opcode, ip_addr, mac_addr, now_ms, resolver_busy,
		output ready);
endinterface

interface arc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  slot_index;
	logic [47:0] mac_out;
	logic [31:0] ip_out;
	logic        send_request;
	logic [31:0] request_ip;

	modport source (output valid, status, slot_index, mac_out, ip_out, send_request,
		request_ip, input ready);
	modport sink (input valid, status, slot_index, mac_out, ip_out, send_request,
		request_ip, output ready);
endinterface

/* rtl/core/arc_ctrl.sv */
// ----------------------------------------------------------------------------
// Address resolution cache controller
// Sequences the record scan, the service read and the write-back of a word.
// ----------------------------------------------------------------------------
module arc_ctrl import arc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_sts_t    sts,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic out_valid_q;
	logic can_commit;

	assign can_commit = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_START;
			ST_START: state_d = sts.is_tick ? ST_TICK : ST_SCAN;
			ST_SCAN:  if (cnt_q == LAST_IDX) state_d = ST_DRAIN;
			ST_TICK:  state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_WRITE;
			ST_WRITE: if (can_commit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_addr = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN:  cmd.scan_rd = 1'b1;
			ST_TICK:  cmd.tick_rd = 1'b1;
			ST_WRITE: cmd.commit = can_commit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/arc_dp.sv */
// ----------------------------------------------------------------------------
// Address resolution cache datapath
// Record memories, scan accumulators, write-back decision and result register.
// ----------------------------------------------------------------------------
module arc_dp import arc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_sts_t     sts,
	input  cfg_t        cfg,
	input  logic [2:0]  opcode,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic [31:0] now_ms,
	input  logic        resolver_busy,
	output logic [1:0]  status,
	output logic [4:0]  slot_index,
	output logic [47:0] mac_out,
	output logic [31:0] ip_out,
	output logic        send_request,
	output logic [31:0] request_ip
);

	logic [31:0] ip_mem    [RECORD_COUNT];
	logic [47:0] mac_mem   [RECORD_COUNT];
	logic [31:0] stamp_mem [RECORD_COUNT];
	logic [3:0]  tries_mem [RECORD_COUNT];
	rec_state_t  state_q   [RECORD_COUNT];

	logic [2:0]  op_q;
	logic [31:0] ip_q, now_q;
	logic [47:0] mac_q;
	logic        busy_q;
	logic [IDX_W-1:0] svc_q, svc_next;

	logic [IDX_W-1:0] rd_addr;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [31:0]      rd_ip_s1, rd_stamp_s1;
	logic [47:0]      rd_mac_s1;
	logic [3:0]       rd_tries_s1;
	rec_state_t       rd_state_s1;

	logic found_q, hit_q, mhit_q, empty_q;
	logic [IDX_W-1:0] found_idx_q, empty_idx_q, best_idx_q;
	logic [31:0] found_stamp_q, best_age_q, mhit_ip_q;
	logic [47:0] hit_mac_q;
	logic [31:0] rd_age;

	logic we_ip, we_mac, we_stamp, we_tries, we_state;
	logic [IDX_W-1:0] wa, pick;
	logic [31:0] w_ip;
	logic [47:0] w_mac;
	logic [3:0]  w_tries;
	rec_state_t  w_state;
	logic [1:0]  res_status;
	logic [4:0]  res_slot;
	logic [47:0] res_mac;
	logic [31:0] res_ip, res_req_ip;
	logic        res_send;
	logic [31:0] tick_age;
	rec_state_t  ts;

	assign sts.is_tick = (op_q == OP_TICK);
	assign svc_next = (svc_q == LAST_IDX) ? '0 : svc_q + 1'b1;
	assign rd_addr = cmd.tick_rd ? svc_next : cmd.rd_addr;
	assign rd_age = now_q - rd_stamp_s1;
	assign pick = empty_q ? empty_idx_q : best_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			ip_q <= ip_addr;
			mac_q <= mac_addr;
			now_q <= now_ms;
			busy_q <= resolver_busy;
		end
		if (cmd.scan_rd || cmd.tick_rd) begin
			rd_idx_s1 <= rd_addr;
			rd_ip_s1 <= ip_mem[rd_addr];
			rd_mac_s1 <= mac_mem[rd_addr];
			rd_stamp_s1 <= stamp_mem[rd_addr];
			rd_tries_s1 <= tries_mem[rd_addr];
			rd_state_s1 <= state_q[rd_addr];
		end
		if (we_ip) ip_mem[wa] <= w_ip;
		if (we_mac) mac_mem[wa] <= w_mac;
		if (we_stamp) stamp_mem[wa] <= now_q;
		if (we_tries) tries_mem[wa] <= w_tries;
		if (cmd.commit) begin
			status <= res_status;
			slot_index <= res_slot;
			mac_out <= res_mac;
			ip_out <= res_ip;
			send_request <= res_send;
			request_ip <= res_req_ip;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			found_q <= 1'b0;
			hit_q <= 1'b0;
			mhit_q <= 1'b0;
			empty_q <= 1'b0;
			best_idx_q <= '0;
			best_age_q <= '0;
		end else if (rd_valid_s1) begin
			if (rd_state_s1 != REC_EMPTY && rd_ip_s1 == ip_q && !found_q) begin
				found_q <= 1'b1;
				found_idx_q <= rd_idx_s1;
				found_stamp_q <= rd_stamp_s1;
			end
			if (rd_state_s1 == REC_VALID && rd_ip_s1 == ip_q && !hit_q) begin
				hit_q <= 1'b1;
				hit_mac_q <= rd_mac_s1;
			end
			if (rd_state_s1 == REC_VALID && rd_mac_s1 == mac_q && !mhit_q) begin
				mhit_q <= 1'b1;
				mhit_ip_q <= rd_ip_s1;
			end
			if (!empty_q) begin
				if (rd_state_s1 == REC_EMPTY) begin
					empty_q <= 1'b1;
					empty_idx_q <= rd_idx_s1;
				end else if (rd_age >= best_age_q) begin
					best_age_q <= rd_age;
					best_idx_q <= rd_idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			svc_q <= LAST_IDX;
			for (int i = 0; i < RECORD_COUNT; i++) state_q[i] <= REC_EMPTY;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.commit && sts.is_tick) svc_q <= svc_next;
			if (we_state) state_q[wa] <= w_state;
		end
	end

	always_comb begin
		we_ip = 1'b0;
		we_mac = 1'b0;
		we_stamp = 1'b0;
		we_tries = 1'b0;
		we_state = 1'b0;
		wa = pick;
		w_ip = ip_q;
		w_mac = mac_q;
		w_tries = '0;
		w_state = REC_WANT;
		res_status = RES_OK;
		res_slot = '0;
		res_mac = '0;
		res_ip = '0;
		res_send = 1'b0;
		res_req_ip = '0;
		tick_age = now_q - rd_stamp_s1;
		ts = rd_state_s1;
		case (op_q)
			OP_REQUEST, OP_CHECK: begin
				if (op_q == OP_CHECK && hit_q) begin
					res_status = RES_OK;
				end else begin
					res_status = (op_q == OP_CHECK) ? RES_MISS : RES_OK;
					if (ip_q == '0) begin
						if (op_q == OP_REQUEST) res_status = RES_REJECT;
					end else if (found_q && (now_q - found_stamp_q) < cfg.freeze_to) begin
						res_status = RES_MISS;
					end else begin
						wa = found_q ? found_idx_q : pick;
						we_state = cmd.commit;
						we_stamp = cmd.commit;
						we_tries = cmd.commit;
						we_ip = cmd.commit && !found_q;
						we_mac = cmd.commit && !found_q;
						w_mac = '0;
					end
				end
			end
			OP_ADD: begin
				if (ip_q == '0 || mac_q == '0) begin
					res_status = RES_REJECT;
				end else begin
					wa = found_q ? found_idx_q : pick;
					w_state = REC_VALID;
					we_state = cmd.commit;
					we_stamp = cmd.commit;
					we_ip = cmd.commit;
					we_mac = cmd.commit;
					res_slot = 5'(wa);
				end
			end
			OP_IP2MAC: begin
				res_status = hit_q ? RES_OK : RES_MISS;
				res_mac = hit_q ? hit_mac_q : '0;
			end
			OP_MAC2IP: begin
				res_status = mhit_q ? RES_OK : RES_MISS;
				res_ip = mhit_q ? mhit_ip_q : '0;
			end
			OP_TICK: begin
				wa = rd_idx_s1;
				if (tick_age >= cfg.cache_to) ts = REC_EMPTY;
				if (ts == REC_SENT && tick_age >= cfg.reply_to) begin
					if (rd_tries_s1 < cfg.attempts) begin
						ts = REC_WANT;
						we_stamp = cmd.commit;
						we_tries = cmd.commit;
						w_tries = rd_tries_s1 + 4'd1;
					end else begin
						ts = REC_EMPTY;
					end
				end
				if (!busy_q && ts == REC_WANT) begin
					res_send = 1'b1;
					res_req_ip = rd_ip_s1;
					ts = REC_SENT;
					we_stamp = cmd.commit;
				end
				w_state = ts;
				we_state = cmd.commit;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/address_resolution_cache.sv */
// ----------------------------------------------------------------------------
// Address resolution cache
// Table of IPv4-to-MAC records with request, learn, lookup and service words.
// ----------------------------------------------------------------------------
// A service tick reads one record, the next in turn, then drains and writes;
// every other word scans all RECORD_COUNT records of the record memory through
// its single read port, one record per cycle, before the drain and write-back.
// One word is in work at a time; the next is taken while a result waits.
// Reset empties every record and restores the default timeouts at once.
module address_resolution_cache import arc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	arc_in_if.sink      in_word,
	arc_out_if.source   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	ctrl_cmd_t cmd;
	dp_sts_t sts;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cache_to <= CACHE_RST;
			cfg_q.freeze_to <= FREEZE_RST;
			cfg_q.reply_to <= REPLY_RST;
			cfg_q.attempts <= ATTEMPTS_RST;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_CACHE:    cfg_q.cache_to <= pwdata;
				REG_FREEZE:   cfg_q.freeze_to <= pwdata;
				REG_REPLY:    cfg_q.reply_to <= pwdata;
				REG_ATTEMPTS: cfg_q.attempts <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CACHE:    prdata = cfg_q.cache_to;
			REG_FREEZE:   prdata = cfg_q.freeze_to;
			REG_REPLY:    prdata = cfg_q.reply_to;
			REG_ATTEMPTS: prdata = {28'd0, cfg_q.attempts};
			default:      prdata = '0;
		endcase
	end

	arc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_word.valid),
		.in_ready  (in_word.ready),
		.out_valid (out_word.valid),
		.out_ready (out_word.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	arc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg_q),
		.opcode        (in_word.opcode),
		.ip_addr       (in_word.ip_addr),
		.mac_addr      (in_word.mac_addr),
		.now_ms        (in_word.now_ms),
		.resolver_busy (in_word.resolver_busy),
		.status        (out_word.status),
		.slot_index    (out_word.slot_index),
		.mac_out       (out_word.mac_out),
		.ip_out        (out_word.ip_out),
		.send_request  (out_word.send_request),
		.request_ip    (out_word.request_ip)
	);

endmodule

/* rtl/core/arc_checker.sv */
// ----------------------------------------------------------------------------
// Address resolution cache checker
// Port-level properties of the cache, bound to the top level.
// ----------------------------------------------------------------------------
module arc_checker import arc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        send_request,
	input logic [31:0] request_ip
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result word dropped before it was taken.");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second word was taken while one was in work.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("Result status carries an unused code.");

	a_send_ip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_request |-> request_ip != '0 && status == RES_OK)
		else $error("Resolve request issued for a zero address.");

endmodule

bind address_resolution_cache arc_checker u_arc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_word.valid),
	.in_ready     (in_word.ready),
	.out_valid    (out_word.valid),
	.out_ready    (out_word.ready),
	.status       (out_word.status),
	.send_request (out_word.send_request),
	.request_ip   (out_word.request_ip)
);
